FILE: sv/sbe_pkg.sv
package sbe_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_NAME_SLOTS  = 16;
	localparam int DEF_SCOPE_DEPTH = 8;
	localparam int DEF_PC_BITS     = 16;

	typedef enum logic [3:0] {
		OP_CONST  = 4'd0,
		OP_ADD    = 4'd1,
		OP_SUB    = 4'd2,
		OP_MUL    = 4'd3,
		OP_DIV    = 4'd4,
		OP_EQ     = 4'd5,
		OP_LESS   = 4'd6,
		OP_DEFINE = 4'd7,
		OP_GET    = 4'd8,
		OP_EMIT   = 4'd9,
		OP_JFALSE = 4'd10,
		OP_JUMP   = 4'd11,
		OP_LOOP   = 4'd12,
		OP_RET    = 4'd13,
		OP_CALL   = 4'd14,
		OP_IN     = 4'd15
	} op_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_UNDER = 3'd1,
		ERR_OVER  = 3'd2,
		ERR_DIVZ  = 3'd3,
		ERR_UNDEF = 3'd4,
		ERR_CALL  = 3'd5
	} err_t;

	typedef struct packed {
		logic [3:0]         op;
		logic [3:0]         name_slot;
		logic [7:0]         branch_offset;
		logic signed [31:0] immediate_value;
		logic [15:0]        call_target;
	} in_word_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic               print_valid;
		logic signed [31:0] print_value;
		logic               halted;
		logic [2:0]         error_code;
		logic [6:0]         stack_level;
	} out_word_t;

endpackage

FILE: sv/stack_bytecode_executor.sv
// An input word passes the read, execute and result states in that order; a divide adds a
// divide state after execute. A new word is taken only in idle, once the last result word
// is accepted; the synchronous read of the stack and variable memories needs the read state.
// Reset (arst_n low, asynchronous): empty stack, pc 0, global scope, no variables defined,
// running with no error. Memory contents are not cleared.
module stack_bytecode_executor
	import sbe_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int NAME_SLOTS  = DEF_NAME_SLOTS,
	parameter int SCOPE_DEPTH = DEF_SCOPE_DEPTH,
	parameter int PC_BITS     = DEF_PC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int LW  = $clog2(STACK_DEPTH + 1);
	localparam int NSW = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
	localparam int SCW = $clog2(SCOPE_DEPTH);
	localparam int VAW = SCW + NSW;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT} state_t;

	state_t state_q;
	in_word_t ins_q;
	logic [LW-1:0] top_q;
	logic [PC_BITS-1:0] pc_q;
	logic [SCW-1:0] scope_q;
	logic halt_q;
	err_t err_q;
	logic [NAME_SLOTS-1:0] defd_q [SCOPE_DEPTH];

	// memories
	logic [31:0] dstack [STACK_DEPTH];
	logic [31:0] vstore [1 << VAW];
	logic [PC_BITS-1:0] rstack [SCOPE_DEPTH];
	logic [31:0] rd_b_q, rd_a_q, rd_v_q;
	logic [PC_BITS-1:0] rd_r_q;

	// second stack port is modeled as a separate read of the same array (two reads, one write)
	logic [SAW-1:0] ra_b, ra_a;
	logic [LW-1:0] top_m1, top_m2;
	assign top_m1 = top_q - LW'(1);
	assign top_m2 = top_q - LW'(2);
	assign ra_b = top_m1[SAW-1:0];
	assign ra_a = top_m2[SAW-1:0];

	// variable lookup: current scope, else global
	logic slot_ok, loc_def, glb_def;
	logic [NSW-1:0] slot;
	assign slot_ok = 32'(ins_q.name_slot) < NAME_SLOTS;
	assign slot = NSW'(ins_q.name_slot);
	assign loc_def = slot_ok && defd_q[scope_q][slot];
	assign glb_def = slot_ok && defd_q[0][slot];
	logic [VAW-1:0] va_rd;
	assign va_rd = loc_def ? {scope_q, slot} : {SCW'(0), slot};
	logic [SCW-1:0] scope_m1;
	assign scope_m1 = scope_q - SCW'(1);

	always_ff @(posedge clk) begin
		rd_b_q <= dstack[ra_b];
		rd_a_q <= dstack[ra_a];
		rd_v_q <= vstore[va_rd];
		rd_r_q <= rstack[scope_m1];
	end

	// divider
	logic [5:0] dcnt_q;
	logic [31:0] dq_q, dr_q, dd_q;
	logic dneg_q;
	logic [32:0] dtrial;
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

	// execute decode
	logic [PC_BITS-1:0] pc1, pc2, nxt;
	logic [31:0] a, b, v, prod;
	err_t e;
	logic stop, printed, ws_en, wv_en;
	logic [LW-1:0] ntop;
	logic [SAW-1:0] ws_addr;
	logic [31:0] ws_data;
	op_t op;
	assign op = op_t'(ins_q.op);
	assign a = rd_a_q;
	assign b = rd_b_q;
	assign prod = a * b;
	assign pc1 = pc_q + PC_BITS'(1);
	assign pc2 = pc_q + PC_BITS'(2);

	always_comb begin
		nxt = pc1; e = ERR_NONE; stop = 1'b0; printed = 1'b0;
		ntop = top_q; ws_en = 1'b0; wv_en = 1'b0; ws_addr = ra_b; ws_data = a; v = '0;
		unique case (op)
			OP_CONST, OP_IN: begin
				if (32'(top_q) >= STACK_DEPTH) e = ERR_OVER;
				else begin
					ws_en = 1'b1; ws_addr = top_q[SAW-1:0];
					ws_data = ins_q.immediate_value; ntop = top_q + LW'(1);
					nxt = (op == OP_CONST) ? pc2 : pc1;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LESS: begin
				if (top_q < LW'(2)) e = ERR_UNDER;
				else if (op == OP_DIV && b == '0) e = ERR_DIVZ;
				else begin
					unique case (op)
						OP_ADD: v = a + b;
						OP_SUB: v = a - b;
						OP_MUL: v = prod;
						OP_EQ: v = {31'b0, a == b};
						default: v = {31'b0, $signed(a) < $signed(b)};
					endcase
					ws_en = (op != OP_DIV); ws_addr = ra_a; ws_data = v;
					ntop = top_m1;
				end
			end
			OP_DEFINE: begin
				if (top_q == '0) e = ERR_UNDER;
				else begin
					ntop = top_m1; wv_en = slot_ok; nxt = pc2;
				end
			end
			OP_GET: begin
				if (!loc_def && !glb_def) e = ERR_UNDEF;
				else if (32'(top_q) >= STACK_DEPTH) e = ERR_OVER;
				else begin
					ws_en = 1'b1; ws_addr = top_q[SAW-1:0]; ws_data = rd_v_q;
					ntop = top_q + LW'(1); nxt = pc2;
				end
			end
			OP_EMIT: begin
				if (top_q == '0) e = ERR_UNDER;
				else begin
					ntop = top_m1; printed = 1'b1;
				end
			end
			OP_JFALSE: begin
				if (top_q == '0) e = ERR_UNDER;
				else begin
					ntop = top_m1;
					nxt = (b == '0) ? pc2 + PC_BITS'(ins_q.branch_offset) : pc2;
				end
			end
			OP_JUMP: nxt = pc2 + PC_BITS'(ins_q.branch_offset);
			OP_LOOP: nxt = pc2 - PC_BITS'(ins_q.branch_offset);
			OP_RET: begin
				if (scope_q == '0) stop = 1'b1;
				else if (top_q == '0) e = ERR_UNDER;
				else nxt = rd_r_q;
			end
			default: begin
				if (32'(scope_q) + 1 >= SCOPE_DEPTH) e = ERR_CALL;
				else nxt = PC_BITS'(ins_q.call_target);
			end
		endcase
	end

	// result word for the instruction in execute
	out_word_t res;
	always_comb begin
		res = '0;
		res.next_pc = 16'(pc_q);
		res.halted = 1'b1;
		res.error_code = err_q;
		res.stack_level = 7'(top_q);
		if (!halt_q) begin
			if (e != ERR_NONE) res.error_code = e;
			else if (!stop) begin
				res.next_pc = 16'(nxt);
				res.halted = 1'b0;
				res.print_valid = printed;
				res.print_value = printed ? b : '0;
				res.stack_level = 7'(ntop);
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk) begin
		if (ws_en && state_q == S_EXEC && !halt_q) dstack[ws_addr] <= ws_data;
		// quotient replaces the lower operand; top already points one past it
		if (state_q == S_DIV && dcnt_q == '0) dstack[ra_b] <= dneg_q ? -dq_q : dq_q;
		if (wv_en && state_q == S_EXEC && !halt_q) vstore[{scope_q, slot}] <= b;
		if (state_q == S_EXEC && !halt_q && op == OP_CALL && e == ERR_NONE)
			rstack[scope_q] <= pc2;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ins_q <= '0;
			top_q <= '0;
			pc_q <= '0;
			scope_q <= '0;
			halt_q <= 1'b0;
			err_q <= ERR_NONE;
			for (int i = 0; i < SCOPE_DEPTH; i++) defd_q[i] <= '0;
			out_data <= '0;
			dcnt_q <= '0;
			dq_q <= '0;
			dd_q <= '0;
			dr_q <= '0;
			dneg_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ins_q <= in_data;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					out_data <= res;
					if (!halt_q && e == ERR_NONE && !stop && op == OP_DIV) state_q <= S_DIV;
					else state_q <= S_OUT;
					if (!halt_q) begin
						if (e != ERR_NONE) begin
							halt_q <= 1'b1; err_q <= e;
						end else if (stop) begin
							halt_q <= 1'b1;
						end else begin
							pc_q <= nxt;
							top_q <= ntop;
							if (wv_en) defd_q[scope_q][slot] <= 1'b1;
							if (op == OP_CALL) begin
								scope_q <= scope_q + SCW'(1);
								defd_q[scope_q + SCW'(1)] <= '0;
							end
							if (op == OP_RET) begin
								defd_q[scope_q] <= '0;
								scope_q <= scope_m1;
							end
							if (op == OP_DIV) begin
								dcnt_q <= 6'd32;
								dq_q <= a[31] ? -a : a;
								dd_q <= b[31] ? -b : b;
								dr_q <= '0;
								dneg_q <= a[31] ^ b[31];
							end
						end
					end
				end
				S_DIV: begin
					if (dcnt_q == '0) state_q <= S_OUT;
					else begin
						dcnt_q <= dcnt_q - 6'd1;
						if (!dtrial[32]) dr_q <= dtrial[31:0];
						else dr_q <= {dr_q[30:0], dq_q[31]};
						dq_q <= {dq_q[30:0], !dtrial[32]};
					end
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/sbe_checker.sv
module sbe_checker
	import sbe_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// print value only with print flag
	a_print: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.print_valid |-> out_data.print_value == '0)
		else $error("print value without print flag");

	// an error always halts
	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != ERR_NONE |-> out_data.halted)
		else $error("error without halt");

	// no new word taken while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

endmodule

bind stack_bytecode_executor sbe_checker u_sbe_checker (.*);
